// ----- hw/rtl/rms_pkg.sv -----
// rms_pkg: shared types, sizes and the sort order compare for the record merge sorter
// no dependencies; imported by rms_store, rms_merge and record_merge_sorter
package rms_pkg;

   // default set size
   localparam int MaxRecords = 64;

   // one input beat
   typedef struct packed {
      logic [5:0]  record_tag;
      logic        mismatch;
      logic [15:0] weight_diff;
      logic [15:0] order_key;
      logic        last_item;
   } req_type;

   // one result beat
   typedef struct packed {
      logic [5:0]  out_tag;
      logic        out_mismatch;
      logic [15:0] out_weight_diff;
      logic [15:0] out_order_key;
      logic        out_last;
   } rsp_type;

   // stored record, 39 bits
   typedef struct packed {
      logic [5:0]  tag;
      logic        flag;
      logic [15:0] diff;
      logic [15:0] key;
   } rec_type;

   // merge engine status toward the top level
   typedef struct packed {
      logic busy;
      logic done;
      logic src_sel;
   } rms_stat_type;

   // true if record a must strictly precede record b
   function automatic logic goes_first(rec_type a, rec_type b);
      logic res;
      begin
         if (a.flag != b.flag) begin
            res = a.flag;
         end else if (a.flag) begin
            res = (a.key < b.key);
         end else if (a.diff != b.diff) begin
            res = (a.diff > b.diff);
         end else begin
            res = (a.key < b.key);
         end
         return res;
      end
   endfunction

endpackage

// ----- hw/rtl/rms_store.sv -----
// rms_store: record memory, one write port and two registered read ports
// depends on rms_pkg for rec_type
module rms_store
   import rms_pkg::*;
#(
   parameter int MAX_RECORDS = MaxRecords
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(MAX_RECORDS)-1:0] wr_addr,
   input  rec_type                        wr_data,
   input  logic [$clog2(MAX_RECORDS)-1:0] rd_addr_a,
   input  logic [$clog2(MAX_RECORDS)-1:0] rd_addr_b,
   output rec_type                        rd_data_a,
   output rec_type                        rd_data_b
);

   rec_type store_ff [MAX_RECORDS];
   rec_type rd_a_ff;
   rec_type rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read ports, registered
   always_ff @(posedge clock) begin
      rd_a_ff <= store_ff[rd_addr_a];
      rd_b_ff <= store_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- hw/rtl/rms_merge.sv -----
// rms_merge: bottom-up merge sort sequencer, one output record per cycle in S_MERGE
// depends on rms_pkg; reads the source store and writes the other one
module rms_merge
   import rms_pkg::*;
#(
   parameter int MAX_RECORDS = MaxRecords
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [$clog2(MAX_RECORDS+1)-1:0] count,
   input  rec_type                          head_i,
   input  rec_type                          head_j,
   output logic [$clog2(MAX_RECORDS)-1:0]   rd_addr_i,
   output logic [$clog2(MAX_RECORDS)-1:0]   rd_addr_j,
   output logic                             wr_en,
   output logic [$clog2(MAX_RECORDS)-1:0]   wr_addr,
   output rec_type                          wr_data,
   output rms_stat_type                     stat
);

   localparam int ADDR_W = $clog2(MAX_RECORDS);
   localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
   localparam int SUM_W  = CNT_W + 2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SETUP,
      S_MERGE
   } state_type;

   state_type          state_ff, state_in;
   logic [SUM_W-1:0]   width_ff, width_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic               src_ff, src_in;
   logic               done_ff, done_in;

   logic [SUM_W-1:0]   n_ext;
   logic [SUM_W-1:0]   lo_plus_w;
   logic [SUM_W-1:0]   lo_plus_2w;
   logic [SUM_W-1:0]   width_dbl;
   logic               i_done;
   logic               j_done;
   logic               take_j;
   logic               run_end;

   // run bounds
   always_comb begin
      n_ext      = SUM_W'(count);
      width_dbl  = width_ff << 1;
      lo_plus_w  = SUM_W'(lo_ff) + width_ff;
      lo_plus_2w = SUM_W'(lo_ff) + width_dbl;
   end

   // head compare and winner pick
   always_comb begin
      i_done = (i_ff == mid_ff);
      j_done = (j_ff == hi_ff);
      if (i_done) begin
         take_j = 1'b1;
      end else if (j_done) begin
         take_j = 1'b0;
      end else begin
         take_j = goes_first(head_j, head_i);
      end
      run_end = ((k_ff + CNT_W'(1)) == hi_ff);
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      width_in = width_ff;
      lo_in    = lo_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      src_in   = src_ff;
      done_in  = 1'b0;
      wr_en    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               src_in   = 1'b0;
               width_in = SUM_W'(1);
               lo_in    = '0;
               if (n_ext <= SUM_W'(1)) begin
                  done_in = 1'b1;
               end else begin
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            mid_in   = (lo_plus_w > n_ext) ? count : lo_plus_w[CNT_W-1:0];
            hi_in    = (lo_plus_2w > n_ext) ? count : lo_plus_2w[CNT_W-1:0];
            i_in     = lo_ff;
            j_in     = mid_in;
            k_in     = lo_ff;
            state_in = S_MERGE;
         end
         S_MERGE: begin
            wr_en = 1'b1;
            k_in  = k_ff + CNT_W'(1);
            if (take_j) begin
               j_in = j_ff + CNT_W'(1);
            end else begin
               i_in = i_ff + CNT_W'(1);
            end
            if (run_end) begin
               state_in = S_SETUP;
               if (lo_plus_2w >= n_ext) begin
                  // pass complete: swap stores, double run width
                  src_in   = ~src_ff;
                  width_in = width_dbl;
                  lo_in    = '0;
                  if (width_dbl >= n_ext) begin
                     state_in = S_IDLE;
                     done_in  = 1'b1;
                  end
               end else begin
                  lo_in = lo_plus_2w[CNT_W-1:0];
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         src_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         src_ff   <= src_in;
         done_ff  <= done_in;
      end
      width_ff <= width_in;
      lo_ff    <= lo_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
   end

   // reads follow the next pointers so heads are ready each cycle
   assign rd_addr_i    = i_in[ADDR_W-1:0];
   assign rd_addr_j    = j_in[ADDR_W-1:0];
   assign wr_addr      = k_ff[ADDR_W-1:0];
   assign wr_data      = take_j ? head_j : head_i;
   assign stat.busy    = (state_ff != S_IDLE);
   assign stat.done    = done_ff;
   assign stat.src_sel = src_ff;

endmodule

// ----- hw/rtl/record_merge_sorter.sv -----
// record_merge_sorter: loads a record set, merge-sorts it and streams it out in order
// depends on rms_pkg, rms_store and rms_merge
//
//   channel   ports                          beat
//   input     req_valid req_ready req_data   one record (req_type)
//   output    rsp_valid rsp_ready rsp_data   one sorted record (rsp_type)
//
// loading takes one cycle per record; records beyond MAX_RECORDS are dropped
// sort of n records: ceil(log2 n) passes, each writing every record once through
// the single write port of the destination store; result beats go out one at a time
// input is held off from the last record until the final result beat is taken
// reset is synchronous, active high, and clears the state, the count, the start strobe and rsp_valid
module record_merge_sorter
   import rms_pkg::*;
#(
   parameter int MAX_RECORDS = MaxRecords
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(MAX_RECORDS);
   localparam int CNT_W  = $clog2(MAX_RECORDS + 1);

   typedef enum logic [2:0] {
      S_LOAD,
      S_SORT,
      S_EMIT_RD,
      S_EMIT_LD,
      S_EMIT_WAIT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] out_idx_ff, out_idx_in;
   logic             start_ff, start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             load_wr;
   rec_type          load_rec;
   logic [CNT_W-1:0] out_idx_nxt;
   logic             emitting;

   logic [ADDR_W-1:0] eng_rd_i;
   logic [ADDR_W-1:0] eng_rd_j;
   logic              eng_wr_en;
   logic [ADDR_W-1:0] eng_wr_addr;
   rec_type           eng_wr_data;
   rms_stat_type      eng_stat;
   rec_type           head_i;
   rec_type           head_j;
   rec_type           out_rec;

   logic              st0_wr_en;
   logic [ADDR_W-1:0] st0_wr_addr;
   rec_type           st0_wr_data;
   logic [ADDR_W-1:0] st0_rd_a;
   logic              st1_wr_en;
   logic [ADDR_W-1:0] st1_rd_a;
   rec_type           st0_data_a, st0_data_b;
   rec_type           st1_data_a, st1_data_b;

   // incoming record
   always_comb begin
      load_rec.tag  = req_data.record_tag;
      load_rec.flag = req_data.mismatch;
      load_rec.diff = req_data.weight_diff;
      load_rec.key  = req_data.order_key;
      load_wr = (state_ff == S_LOAD) && req_valid && (count_ff < CNT_W'(MAX_RECORDS));
   end

   // store port steering: store 0 takes loads, merge writes go to the non-source store
   always_comb begin
      emitting    = (state_ff == S_EMIT_RD) || (state_ff == S_EMIT_LD) ||
                    (state_ff == S_EMIT_WAIT);
      st0_wr_en   = load_wr || (eng_wr_en && eng_stat.src_sel);
      st0_wr_addr = load_wr ? count_ff[ADDR_W-1:0] : eng_wr_addr;
      st0_wr_data = load_wr ? load_rec : eng_wr_data;
      st1_wr_en   = eng_wr_en && !eng_stat.src_sel;
      st0_rd_a    = (emitting && !eng_stat.src_sel) ? out_idx_ff[ADDR_W-1:0] : eng_rd_i;
      st1_rd_a    = (emitting && eng_stat.src_sel) ? out_idx_ff[ADDR_W-1:0] : eng_rd_i;
      head_i      = eng_stat.src_sel ? st1_data_a : st0_data_a;
      head_j      = eng_stat.src_sel ? st1_data_b : st0_data_b;
      out_rec     = head_i;
   end

   rms_store #(
      .MAX_RECORDS(MAX_RECORDS)
   ) u_store0 (
      .clock     (clock),
      .wr_en     (st0_wr_en),
      .wr_addr   (st0_wr_addr),
      .wr_data   (st0_wr_data),
      .rd_addr_a (st0_rd_a),
      .rd_addr_b (eng_rd_j),
      .rd_data_a (st0_data_a),
      .rd_data_b (st0_data_b)
   );

   rms_store #(
      .MAX_RECORDS(MAX_RECORDS)
   ) u_store1 (
      .clock     (clock),
      .wr_en     (st1_wr_en),
      .wr_addr   (eng_wr_addr),
      .wr_data   (eng_wr_data),
      .rd_addr_a (st1_rd_a),
      .rd_addr_b (eng_rd_j),
      .rd_data_a (st1_data_a),
      .rd_data_b (st1_data_b)
   );

   rms_merge #(
      .MAX_RECORDS(MAX_RECORDS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .count     (count_ff),
      .head_i    (head_i),
      .head_j    (head_j),
      .rd_addr_i (eng_rd_i),
      .rd_addr_j (eng_rd_j),
      .wr_en     (eng_wr_en),
      .wr_addr   (eng_wr_addr),
      .wr_data   (eng_wr_data),
      .stat      (eng_stat)
   );

   // load, sort and emit control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      out_idx_in   = out_idx_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      out_idx_nxt  = out_idx_ff + CNT_W'(1);
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (load_wr) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_data.last_item) begin
                  start_in = 1'b1;
                  state_in = S_SORT;
               end
            end
         end
         S_SORT: begin
            out_idx_in = '0;
            if (eng_stat.done) begin
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            rsp_in.out_tag         = out_rec.tag;
            rsp_in.out_mismatch    = out_rec.flag;
            rsp_in.out_weight_diff = out_rec.diff;
            rsp_in.out_order_key   = out_rec.key;
            rsp_in.out_last        = (out_idx_nxt == count_ff);
            rsp_valid_in           = 1'b1;
            state_in               = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.out_last) begin
                  count_in = '0;
                  state_in = S_LOAD;
               end else begin
                  out_idx_in = out_idx_nxt;
                  state_in   = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // control and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_idx_ff <= out_idx_in;
      rsp_ff     <= rsp_in;
   end

   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
